/* src/mlfp_pkg.sv */
// Package for the magic/length frame parser: event codes, result struct,
// register indexes and the magic byte table. No dependencies.
package mlfp_pkg;

  localparam int unsigned MAGIC_LEN  = 5;
  localparam int unsigned HEADER_LEN = MAGIC_LEN + 2;
  localparam int unsigned POS_W      = 10;
  localparam int unsigned LIMIT_W    = 9;

  localparam logic [LIMIT_W-1:0] SSID_LIMIT_RST = LIMIT_W'(33);
  localparam logic [LIMIT_W-1:0] PASS_LIMIT_RST = LIMIT_W'(65);

  // configuration register indexes
  localparam logic CFG_SSID_LIMIT = 1'b0;
  localparam logic CFG_PASS_LIMIT = 1'b1;

  typedef enum logic [2:0] {
    EV_HUNT     = 3'd0,
    EV_SSID_LEN = 3'd1,
    EV_ACCEPT   = 3'd2,
    EV_SSID     = 3'd3,
    EV_PASS     = 3'd4,
    EV_REJECT   = 3'd5
  } event_t;

  typedef struct packed {
    event_t     ev;
    logic [7:0] data_byte;
    logic [7:0] section_index;
    logic       frame_end;
  } res_t;

  function automatic logic [7:0] magic_byte(input logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0:    b = 8'h52;
      3'd1:    b = 8'h4C;
      3'd2:    b = 8'h45;
      3'd3:    b = 8'h44;
      3'd4:    b = 8'h53;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

/* src/magic_length_frame_parser_unit.sv */
// Top level of the magic/length frame parser: input register, limit
// registers, parser step logic and result register. Depends on mlfp_pkg, mlfp_parser.
//
// Usage:
//   in_*  : one received byte per transaction (in_tdata).
//   out_* : one result per input byte. out_tdata = {section_index, data_byte},
//           out_tuser = event code, out_tlast = last byte of a valid frame.
//   cfg_* : write-only limit registers (index 0 ssid limit, 1 password limit);
//           the user must write them only while the block is idle; the block does not enforce it.
// Path: a byte is held in the input register, then its result in the result register.
// Throughput: one byte per cycle while results are taken. The input register
// feeds the parser, whose state and the result register update at the same edge.
// Reset: clears both valid flags, the parser state (hunt restarts) and sets
// the limits to 33 and 65.
// Stall: when out_tready is low the result holds, one more byte waits in the
// input register, and in_tready then drops until the result is taken.
module magic_length_frame_parser_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [7:0]                   in_tdata,   // [7:0] rx_byte
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [15:0]                  out_tdata,  // [7:0] data_byte, [15:8] section_index
  output logic [2:0]                   out_tuser,  // [2:0] event_res
  output logic                         out_tlast,  // frame_end
  input  logic                         cfg_we,
  input  logic                         cfg_addr,
  input  logic [mlfp_pkg::LIMIT_W-1:0] cfg_wdata
);
  import mlfp_pkg::*;

  logic               in_valid_r;
  logic [7:0]         in_byte_r;
  logic               out_valid_r;
  res_t               res, res_r;
  logic [LIMIT_W-1:0] ssid_limit_r, pass_limit_r;
  logic               advance;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ssid_limit_r <= SSID_LIMIT_RST;
      pass_limit_r <= PASS_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_SSID_LIMIT: ssid_limit_r <= cfg_wdata;
        CFG_PASS_LIMIT: pass_limit_r <= cfg_wdata;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
    end
  end

  mlfp_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (advance),
    .rx_byte    (in_byte_r),
    .ssid_limit (ssid_limit_r),
    .pass_limit (pass_limit_r),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {res_r.section_index, res_r.data_byte};
  assign out_tuser  = res_r.ev;
  assign out_tlast  = res_r.frame_end;

endmodule

/* src/mlfp_parser.sv */
// Frame parser state and per-byte step logic.
// Depends on mlfp_pkg.
module mlfp_parser (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,
  input  logic [7:0]                    rx_byte,
  input  logic [mlfp_pkg::LIMIT_W-1:0]  ssid_limit,
  input  logic [mlfp_pkg::LIMIT_W-1:0]  pass_limit,
  output mlfp_pkg::res_t                res
);
  import mlfp_pkg::*;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       ssid_size_r, ssid_size_nxt;
  logic [POS_W-1:0] exp_len_r, exp_len_nxt;

  always_comb begin
    logic [POS_W-1:0] k;
    logic [POS_W-1:0] pos_inc;
    pos_nxt       = pos_r;
    ssid_size_nxt = ssid_size_r;
    exp_len_nxt   = exp_len_r;
    res.ev        = EV_HUNT;
    res.data_byte = rx_byte;
    res.section_index = 8'd0;
    res.frame_end = 1'b0;
    k       = pos_r - POS_W'(HEADER_LEN);
    pos_inc = pos_r + POS_W'(1);

    if (pos_r < POS_W'(MAGIC_LEN)) begin
      if (rx_byte == magic_byte(pos_r[2:0])) begin
        pos_nxt = pos_inc;
      end else begin
        // simple restart: a mismatching 'R' opens a new magic
        pos_nxt       = (rx_byte == magic_byte(3'd0)) ? POS_W'(1) : '0;
        ssid_size_nxt = '0;
        exp_len_nxt   = '0;
      end
    end else if (pos_r == POS_W'(MAGIC_LEN)) begin
      ssid_size_nxt = rx_byte;
      pos_nxt       = POS_W'(HEADER_LEN - 1);
      res.ev        = EV_SSID_LEN;
    end else if (pos_r == POS_W'(HEADER_LEN - 1)) begin
      if (ssid_size_r == 8'd0 || {1'b0, ssid_size_r} >= ssid_limit ||
          {1'b0, rx_byte} >= pass_limit) begin
        pos_nxt       = '0;
        ssid_size_nxt = '0;
        exp_len_nxt   = '0;
        res.ev        = EV_REJECT;
      end else begin
        exp_len_nxt = POS_W'(HEADER_LEN) + POS_W'(ssid_size_r) + POS_W'(rx_byte);
        pos_nxt     = POS_W'(HEADER_LEN);
        res.ev      = EV_ACCEPT;
      end
    end else begin
      if (k < POS_W'(ssid_size_r)) begin
        res.ev            = EV_SSID;
        res.section_index = k[7:0];
      end else begin
        res.ev            = EV_PASS;
        res.section_index = k[7:0] - ssid_size_r;
      end
      pos_nxt = pos_inc;
      if (pos_inc >= exp_len_r) begin
        res.frame_end = 1'b1;
        pos_nxt       = '0;
        ssid_size_nxt = '0;
        exp_len_nxt   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      ssid_size_r <= '0;
      exp_len_r   <= '0;
    end else if (step) begin
      pos_r       <= pos_nxt;
      ssid_size_r <= ssid_size_nxt;
      exp_len_r   <= exp_len_nxt;
    end
  end

endmodule

/* src/mlfp_checker.sv */
// Port-level checks for the magic/length frame parser, bound to the top level.
// Depends on mlfp_pkg and magic_length_frame_parser_unit.
module mlfp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic [2:0]  out_tuser,
  input logic        out_tlast
);
  import mlfp_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

  // input only blocks behind a stalled result
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input blocked while output free");

  // frame end only on a section byte
  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser == EV_SSID || out_tuser == EV_PASS)
    else $error("frame end outside data section");

  // section index is zero outside the data sections
  a_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != EV_SSID && out_tuser != EV_PASS
    |-> out_tdata[15:8] == 8'd0)
    else $error("section index set on header event");

  // nothing comes out the cycle after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind magic_length_frame_parser_unit mlfp_checker u_mlfp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

/* tb/tb_magic_length_frame_parser_unit.sv */
// Self-checking testbench for magic_length_frame_parser_unit: directed header cases,
// limit register sweeps and random frame traffic under sender idling and receiver stalls.
// Depends on mlfp_pkg and the parser RTL; every result is checked against an in-bench model.
module tb_magic_length_frame_parser_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import mlfp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam logic [7:0] SYNC_WORD [MAGIC_LEN] = '{8'h52, 8'h4C, 8'h45, 8'h44, 8'h53};

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               in_tvalid  = 1'b0;
  logic               in_tready;
  logic [7:0]         in_tdata   = 8'h00;   // [7:0] rx_byte
  logic               out_tvalid;
  logic               out_tready = 1'b1;
  logic [15:0]        out_tdata;            // [7:0] data_byte, [15:8] section_index
  logic [2:0]         out_tuser;            // [2:0] event_res
  logic               out_tlast;            // frame_end
  logic               cfg_we     = 1'b0;
  logic               cfg_addr   = CFG_SSID_LIMIT;
  logic [LIMIT_W-1:0] cfg_wdata  = '0;

  magic_length_frame_parser_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // parser shadow state and limits
  logic [POS_W-1:0]   frame_pos;
  logic [7:0]         ssid_size;
  logic [POS_W-1:0]   frame_len;
  logic [LIMIT_W-1:0] ssid_limit;
  logic [LIMIT_W-1:0] pass_limit;

  res_t        expected_results [$];
  event_t      last_event;
  int unsigned idle_pct   = 0;
  int unsigned stall_pct  = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_cnt  = 0;
  int unsigned bytes_sent = 0;
  int unsigned n_accept   = 0;
  int unsigned n_reject   = 0;
  int unsigned n_frames   = 0;

  function automatic void restart_hunt();
    frame_pos = '0;
    ssid_size = '0;
    frame_len = '0;
  endfunction

  function automatic res_t parse_byte(input logic [7:0] b);
    res_t             r;
    logic [POS_W-1:0] k;
    r.ev            = EV_HUNT;
    r.data_byte     = b;
    r.section_index = 8'h00;
    r.frame_end     = 1'b0;
    if (frame_pos < MAGIC_LEN) begin
      if (b == SYNC_WORD[frame_pos]) begin
        frame_pos = frame_pos + 1'b1;
      end else begin
        restart_hunt();
        if (b == SYNC_WORD[0]) frame_pos = POS_W'(1);
      end
    end else if (frame_pos == MAGIC_LEN) begin
      ssid_size = b;
      frame_pos = POS_W'(HEADER_LEN - 1);
      r.ev      = EV_SSID_LEN;
    end else if (frame_pos == HEADER_LEN - 1) begin
      if (ssid_size == 0 || ssid_size >= ssid_limit || b >= pass_limit) begin
        restart_hunt();
        r.ev = EV_REJECT;
      end else begin
        frame_len = POS_W'(HEADER_LEN + ssid_size + b);
        frame_pos = POS_W'(HEADER_LEN);
        r.ev      = EV_ACCEPT;
      end
    end else begin
      k = frame_pos - POS_W'(HEADER_LEN);
      if (k < ssid_size) begin
        r.ev            = EV_SSID;
        r.section_index = k[7:0];
      end else begin
        r.ev            = EV_PASS;
        r.section_index = 8'(k - ssid_size);
      end
      frame_pos = frame_pos + 1'b1;
      if (frame_pos >= frame_len) begin
        r.frame_end = 1'b1;
        restart_hunt();
      end
    end
    return r;
  endfunction

  function automatic logic [7:0] clip8(input int v);
    if (v < 0) return 8'h00;
    if (v > 255) return 8'hFF;
    return v[7:0];
  endfunction

  // mostly short sections, sometimes right at or just under the limit, sometimes anything
  function automatic logic [7:0] pick_len(input logic [LIMIT_W-1:0] lim);
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: return 8'($urandom_range(6));
      6:                return clip8(int'(lim) - 1);
      7:                return clip8(int'(lim));
      default:          return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b);
    res_t r;
    if ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      while ($urandom_range(99) < idle_pct) @(posedge clk);
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    r = parse_byte(b);
    last_event = r.ev;
    expected_results.push_back(r);
    bytes_sent++;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic stop_sending();
    in_tvalid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // leaves cfg_we high; the caller drops it after the last write
  task automatic write_reg(input logic addr, input logic [LIMIT_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= val;
    if (addr == CFG_SSID_LIMIT) ssid_limit = val;
    else pass_limit = val;
    @(posedge clk);
  endtask

  task automatic set_limits(input logic [LIMIT_W-1:0] s_lim, input logic [LIMIT_W-1:0] p_lim);
    stop_sending();
    wait_idle();
    write_reg(CFG_SSID_LIMIT, s_lim);
    write_reg(CFG_PASS_LIMIT, p_lim);
    cfg_we <= 1'b0;
  endtask

  task automatic send_magic();
    for (int i = 0; i < MAGIC_LEN; i++) send_byte(SYNC_WORD[i]);
  endtask

  // header plus payload when the header gets through; keep_pct < 100 cuts the payload short
  task automatic send_frame(input logic [7:0] s_len, input logic [7:0] p_len,
                            input int unsigned keep_pct);
    int unsigned n;
    send_magic();
    send_byte(s_len);
    send_byte(p_len);
    if (last_event == EV_ACCEPT) begin
      n = s_len + p_len;
      if (keep_pct < 100) n = (n * keep_pct) / 100;
      for (int unsigned i = 0; i < n; i++) send_byte(8'($urandom_range(255)));
    end
  endtask

  task automatic test_directed();
    // restart on mismatch, the breaking R starts a new hunt; zero ssid length rejected
    send_byte(8'h52);
    send_byte(8'h4C);
    send_magic();
    send_byte(8'h00);
    send_byte(8'h00);
    // zero password length: frame ends on the single ssid byte
    send_magic();
    send_byte(8'h01);
    send_byte(8'h00);
    send_byte(8'hFF);
    // one ssid byte and one password byte, random data
    send_frame(8'h01, 8'h01, 100);
    // ssid length at the default limit is rejected
    send_byte(8'h00);
    send_magic();
    send_byte(8'd33);
    send_byte(8'h00);
  endtask

  task automatic test_limit_extremes();
    logic [LIMIT_W-1:0] lims [6][2] = '{'{9'd0, 9'd0}, '{9'd1, 9'd1}, '{9'd2, 9'd1},
                                        '{9'd256, 9'd256}, '{9'd511, 9'd1},
                                        '{SSID_LIMIT_RST, PASS_LIMIT_RST}};
    for (int i = 0; i < 6; i++) begin
      set_limits(lims[i][0], lims[i][1]);
      send_frame(8'h01, 8'h00, 100);
      send_frame(clip8(int'(ssid_limit) - 1), clip8(int'(pass_limit) - 1), 100);
      // at-limit lengths only where the limit fits in a byte
      if (ssid_limit < 256) send_frame(clip8(int'(ssid_limit)), 8'h00, 100);
      if (pass_limit < 256) send_frame(8'h01, clip8(int'(pass_limit)), 100);
      send_frame(8'h02, 8'h03, 100);
    end
  endtask

  task automatic test_random_traffic(input int unsigned idle, input int unsigned stall,
                                     input int unsigned n_items);
    int unsigned goal;
    int unsigned k;
    logic [LIMIT_W-1:0] s_lim;
    logic [LIMIT_W-1:0] p_lim;
    case ($urandom_range(3))
      0:       s_lim = SSID_LIMIT_RST;
      1:       s_lim = 9'd256;
      2:       s_lim = 9'd511;
      default: s_lim = 9'($urandom_range(2, 64));
    endcase
    case ($urandom_range(4))
      0:       p_lim = PASS_LIMIT_RST;
      1:       p_lim = 9'd1;
      2:       p_lim = 9'd256;
      3:       p_lim = 9'd511;
      default: p_lim = 9'($urandom_range(1, 96));
    endcase
    set_limits(s_lim, p_lim);
    idle_pct  = idle;
    stall_pct = stall;
    goal = bytes_sent + n_items;
    while (bytes_sent < goal) begin
      case ($urandom_range(9))
        0: begin
          // noise, biased toward sync bytes
          repeat ($urandom_range(1, 6)) begin
            if ($urandom_range(3) == 0) send_byte(SYNC_WORD[$urandom_range(MAGIC_LEN - 1)]);
            else send_byte(8'($urandom_range(255)));
          end
        end
        1: begin
          // broken sync word
          k = $urandom_range(1, MAGIC_LEN - 1);
          for (int unsigned i = 0; i < k; i++) send_byte(SYNC_WORD[i]);
          send_byte(8'($urandom_range(255)));
        end
        2: send_frame(pick_len(ssid_limit), pick_len(pass_limit), $urandom_range(99));
        default: send_frame(pick_len(ssid_limit), pick_len(pass_limit), 100);
      endcase
    end
    stop_sending();
    wait_idle();
    idle_pct  = 0;
    stall_pct = 0;
  endtask

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("[%0t] mismatch: %s", $time, what);
  endtask

  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        flag_mismatch($sformatf("result with nothing pending: ev %0d byte %02h",
                                out_tuser, out_tdata[7:0]));
      end else begin
        want = expected_results.pop_front();
        if (out_tuser !== want.ev)
          flag_mismatch($sformatf("event exp %0d got %0d", want.ev, out_tuser));
        if (out_tdata[7:0] !== want.data_byte)
          flag_mismatch($sformatf("data_byte exp %02h got %02h", want.data_byte,
                                  out_tdata[7:0]));
        if (out_tdata[15:8] !== want.section_index)
          flag_mismatch($sformatf("section_index exp %0d got %0d", want.section_index,
                                  out_tdata[15:8]));
        if (out_tlast !== want.frame_end)
          flag_mismatch($sformatf("frame_end exp %0b got %0b", want.frame_end, out_tlast));
        if (want.ev == EV_ACCEPT) n_accept++;
        if (want.ev == EV_REJECT) n_reject++;
        if (want.frame_end) n_frames++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_cnt,
               expected_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    ssid_limit = SSID_LIMIT_RST;
    pass_limit = PASS_LIMIT_RST;
    restart_hunt();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_limit_extremes();
    set_limits(SSID_LIMIT_RST, PASS_LIMIT_RST);
    test_random_traffic(0, 0, 100);
    test_random_traffic(60, 0, 100);
    test_random_traffic(0, 60, 100);
    test_random_traffic(18, 18, 100);

    stop_sending();
    wait_idle();
    $display("sent %0d bytes: %0d headers accepted, %0d rejected, %0d frames completed",
             bytes_sent, n_accept, n_reject, n_frames);
    $display("limit sweep 0..511, four idle/stall mixes, %0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* magic_length_frame_parser_unit.f */
src/mlfp_pkg.sv
src/mlfp_parser.sv
src/magic_length_frame_parser_unit.sv
src/mlfp_checker.sv
tb/tb_magic_length_frame_parser_unit.sv
